// ===== src/efd_pkg.sv =====
// efd_pkg: shared types and constants for the escaped frame deframer.
// Used by efd_decode and escaped_frame_deframer; no dependencies.
package efd_pkg;

  localparam int MAX_BODY_DEF = 100;

  localparam logic [7:0] BYTE_END = 8'hFF;
  localparam logic [7:0] BYTE_ESC = 8'hFE;
  localparam logic [7:0] ESC_ADD  = 8'd2;

  localparam logic [7:0] IDX_SIGN    = 8'd4;
  localparam logic [7:0] IDX_SEQ_LO  = 8'd5;
  localparam logic [7:0] IDX_SEQ_HI  = 8'd6;
  localparam logic [7:0] IDX_PAYLOAD = 8'd7;

  localparam logic [7:0] COUNT_SAT = 8'd255;
  localparam logic [7:0] PC_CAP    = 8'd127;

  typedef enum logic [1:0] {
    KIND_SIGN    = 2'd0,
    KIND_SEQ     = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        good;
    logic [6:0]  count;
  } res_t;

endpackage

// ===== src/efd_decode.sv =====
// efd_decode: framing state and per-byte decode; result is combinational
// from the accepted byte. Depends on efd_pkg.
module efd_decode import efd_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [7:0] MaxBody = 8'(MAX_BODY);

  phase_t     phase, phase_next;
  logic       esc, esc_next;
  logic [7:0] exp_len, exp_len_next;
  logic [7:0] body_count, body_count_next;
  logic       ovf, ovf_next;
  logic [7:0] seq_lo, seq_lo_next;

  logic [7:0] v;
  logic [7:0] stored;
  logic [7:0] pc8;

  always_comb begin
    v      = esc ? (rx_byte + ESC_ADD) : rx_byte;
    stored = (body_count > MaxBody) ? MaxBody : body_count;
    pc8    = (stored > IDX_PAYLOAD) ? (stored - IDX_PAYLOAD) : 8'd0;
  end

  always_comb begin
    phase_next      = phase;
    esc_next        = esc;
    exp_len_next    = exp_len;
    body_count_next = body_count;
    ovf_next        = ovf;
    seq_lo_next     = seq_lo;
    res_valid       = 1'b0;
    res.kind        = KIND_SIGN;
    res.value       = 16'd0;
    res.good        = 1'b0;
    res.count       = 7'd0;
    if (phase == PH_IDLE) begin
      if (rx_byte == BYTE_ESC) begin
        phase_next      = PH_LEN;
        esc_next        = 1'b0;
        exp_len_next    = 8'd0;
        body_count_next = 8'd0;
        ovf_next        = 1'b0;
        seq_lo_next     = 8'd0;
      end
    end else if (rx_byte == BYTE_END) begin
      res_valid       = 1'b1;
      res.kind        = KIND_END;
      res.good        = (body_count == exp_len) && !ovf;
      res.count       = (pc8 > PC_CAP) ? PC_CAP[6:0] : pc8[6:0];
      phase_next      = PH_IDLE;
      esc_next        = 1'b0;
      exp_len_next    = 8'd0;
      body_count_next = 8'd0;
      ovf_next        = 1'b0;
      seq_lo_next     = 8'd0;
    end else if (rx_byte == BYTE_ESC) begin
      esc_next = 1'b1;
    end else if (phase == PH_LEN) begin
      exp_len_next = rx_byte;
      phase_next   = PH_BODY;
    end else begin
      esc_next = 1'b0;
      if (body_count != COUNT_SAT) begin
        body_count_next = body_count + 8'd1;
      end
      if (body_count >= MaxBody) begin
        ovf_next = 1'b1;
      end else if (body_count == IDX_SIGN) begin
        res_valid = 1'b1;
        res.kind  = KIND_SIGN;
        res.value = {8'd0, v};
      end else if (body_count == IDX_SEQ_LO) begin
        seq_lo_next = v;
      end else if (body_count == IDX_SEQ_HI) begin
        res_valid = 1'b1;
        res.kind  = KIND_SEQ;
        res.value = {v, seq_lo};
      end else if (body_count >= IDX_PAYLOAD) begin
        res_valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.value = {8'd0, v};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      esc        <= 1'b0;
      exp_len    <= 8'd0;
      body_count <= 8'd0;
      ovf        <= 1'b0;
      seq_lo     <= 8'd0;
    end else if (fire) begin
      phase      <= phase_next;
      esc        <= esc_next;
      exp_len    <= exp_len_next;
      body_count <= body_count_next;
      ovf        <= ovf_next;
      seq_lo     <= seq_lo_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (body_count == 8'd0 && !esc && !ovf && exp_len == 8'd0))
    else $error("idle phase with stale frame state");

  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (body_count >= MaxBody))
    else $error("overflow flag without count past limit");

endmodule

// ===== src/escaped_frame_deframer.sv =====
// escaped_frame_deframer: top level, byte decode plus registered output
// with a one-entry skid stage. Depends on efd_pkg and efd_decode.
//
// Input channel: one raw serial byte (rx_byte) per transaction, on
// in_valid / in_stall. Output channel: out_kind, out_value, frame_good and
// payload_count per transaction, on out_valid / out_stall.
// 0xFE opens a frame from idle, the next ordinary byte is the length,
// 0xFE inside a frame escapes the next byte (+2), 0xFF closes the frame
// and produces an end marker. Body bytes 4, 5-6 and 7 up to MAX_BODY-1
// come out as sign, sequence word and payload; other body bytes give nothing.
// Throughput: one byte per cycle while in_stall is low. A result goes to the
// output register, or to the skid stage while that is stalled. Decode is
// a single pass of compare/add logic from framing state to output register.
// While the receiver stalls, one further result is held in the skid stage;
// in_stall is raised only while that stage is occupied.
// Reset returns the framing to idle and empties the output stages.
module escaped_frame_deframer import efd_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_value,
  output logic        frame_good,
  output logic [6:0]  payload_count
);

  logic fire;
  logic res_valid;
  res_t res;
  logic push;

  res_t out_res;
  logic skid_valid;
  res_t skid_res;

  assign in_stall = skid_valid;
  assign fire     = in_valid && !in_stall;
  assign push     = fire && res_valid;

  efd_decode #(
    .MAX_BODY (MAX_BODY)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res   <= res;
        out_valid <= push;
      end
    end else if (push) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign out_kind      = out_res.kind;
  assign out_value     = out_res.value;
  assign frame_good    = out_res.good;
  assign payload_count = out_res.count;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && out_stall) |=> skid_valid)
    else $error("result lost while output stalled");

  a_end_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == KIND_END) |-> out_res.value == 16'd0)
    else $error("end marker carries a value");

  a_byte_kinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind == KIND_SIGN || out_res.kind == KIND_PAYLOAD))
      |-> (out_res.value[15:8] == 8'd0 && !out_res.good && out_res.count == 7'd0))
    else $error("byte result with stray upper bits or end fields");

endmodule

// ===== verif/escaped_frame_deframer_tb.sv =====
// escaped_frame_deframer_tb: self-checking bench for the escaped frame deframer.
// Feeds directed and random byte-stuffed frames, predicts every output
// transaction in-bench and checks it. Depends on efd_pkg and escaped_frame_deframer.
module escaped_frame_deframer_tb;
  import efd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    HUNT,
    GET_LEN,
    IN_BODY
  } rx_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_value;
  logic        frame_good;
  logic [6:0]  payload_count;

  escaped_frame_deframer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_value(out_value),
    .frame_good(frame_good),
    .payload_count(payload_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // in-bench framing state
  rx_phase_t  ph;
  logic       esc_armed;
  logic [7:0] want_len;
  logic [7:0] got_cnt;
  logic       over;
  logic [7:0] seq_lo;

  logic [7:0] tx_bytes[$];
  res_t       due_results[$];
  bit         in_held = 0;
  int         gap_pct = 29;
  int         quiet_cycles = 0;
  int         err_cnt = 0;
  int         n_fed = 0;
  res_t       got_res;
  res_t       want_res;
  bit         moved;

  function automatic void clear_frame();
    ph = HUNT;
    esc_armed = 1'b0;
    want_len = '0;
    got_cnt = '0;
    over = 1'b0;
    seq_lo = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    int kept;
    int pcnt;
    logic [7:0] v;
    logic [7:0] idx;
    r = '0;
    if (ph == HUNT) begin
      if (b == BYTE_ESC) begin
        clear_frame();
        ph = GET_LEN;
      end
      return 0;
    end
    if (b == BYTE_END) begin
      kept = (got_cnt > MAX_BODY_DEF) ? MAX_BODY_DEF : int'(got_cnt);
      pcnt = (kept > int'(IDX_PAYLOAD)) ? kept - int'(IDX_PAYLOAD) : 0;
      if (pcnt > int'(PC_CAP)) pcnt = int'(PC_CAP);
      r.kind = KIND_END;
      r.good = (got_cnt == want_len) && !over;
      r.count = 7'(pcnt);
      clear_frame();
      return 1;
    end
    if (b == BYTE_ESC) begin
      esc_armed = 1'b1;
      return 0;
    end
    if (ph == GET_LEN) begin
      want_len = b;
      ph = IN_BODY;
      return 0;
    end
    idx = got_cnt;
    v = b;
    if (esc_armed) begin
      v = b + ESC_ADD;
      esc_armed = 1'b0;
    end
    if (got_cnt != COUNT_SAT) got_cnt = got_cnt + 8'd1;
    if (idx >= MAX_BODY_DEF) begin
      over = 1'b1;
      return 0;
    end
    if (idx == IDX_SIGN) begin
      r.kind = KIND_SIGN;
      r.value = {8'h00, v};
      return 1;
    end
    if (idx == IDX_SEQ_LO) begin
      seq_lo = v;
      return 0;
    end
    if (idx == IDX_SEQ_HI) begin
      r.kind = KIND_SEQ;
      r.value = {v, seq_lo};
      return 1;
    end
    if (idx >= IDX_PAYLOAD) begin
      r.kind = KIND_PAYLOAD;
      r.value = {8'h00, v};
      return 1;
    end
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < gap_pct);
      if (!in_held) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          rx_byte <= tx_bytes.pop_front();
          in_valid <= 1'b1;
          in_held = 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      moved = 0;
      if (in_valid && !in_stall) begin
        if (deframe_byte(rx_byte, got_res)) due_results.push_back(got_res);
        in_held = 0;
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        moved = 1;
        if (due_results.size() == 0) begin
          $error("unexpected output transaction: kind %0d value %0h", out_kind, out_value);
          err_cnt++;
        end else begin
          want_res = due_results.pop_front();
          if (out_kind !== want_res.kind) begin
            $error("out_kind: expected %0d, got %0d", want_res.kind, out_kind);
            err_cnt++;
          end
          if (out_value !== want_res.value) begin
            $error("out_value: expected %0h, got %0h", want_res.value, out_value);
            err_cnt++;
          end
          if (frame_good !== want_res.good) begin
            $error("frame_good: expected %0d, got %0d", want_res.good, frame_good);
            err_cnt++;
          end
          if (payload_count !== want_res.count) begin
            $error("payload_count: expected %0d, got %0d", want_res.count, payload_count);
            err_cnt++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  task automatic feed(input logic [7:0] b);
    tx_bytes.push_back(b);
    n_fed++;
  endtask

  task automatic push_frame(input int blen, input int lfield, input int esc_pct, input bit close);
    feed(BYTE_ESC);
    if ($urandom_range(19) == 0) feed(BYTE_ESC);
    feed(8'(lfield));
    for (int i = 0; i < blen; i++) begin
      if ($urandom_range(99) < esc_pct) begin
        feed(BYTE_ESC);
        if ($urandom_range(7) == 0) feed(BYTE_ESC);
      end
      feed(8'($urandom_range(253)));
    end
    if (close) feed(BYTE_END);
  endtask

  task automatic random_traffic(input int n);
    int start;
    int sel;
    int blen;
    int lfield;
    start = n_fed;
    while (n_fed - start < n) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        case ($urandom_range(24))
          0:       blen = $urandom_range(100, 120);
          1, 2:    blen = $urandom_range(25, 99);
          default: blen = $urandom_range(0, 24);
        endcase
        lfield = ($urandom_range(4) == 0) ? $urandom_range(253) : blen;
        push_frame(blen, lfield, 15, 1);
      end else if (sel < 83) begin
        repeat ($urandom_range(1, 5)) feed(8'($urandom_range(255)));
      end else if (sel < 88) begin
        feed(BYTE_ESC);
        feed(BYTE_END);
      end else if (sel < 94) begin
        feed(BYTE_ESC);
        repeat ($urandom_range(1, 3)) feed(BYTE_ESC);
        blen = $urandom_range(0, 12);
        feed(8'(blen));
        repeat (blen) feed(8'($urandom_range(253)));
        feed(BYTE_END);
      end else begin
        push_frame($urandom_range(0, 15), $urandom_range(253), 15, 0);
        repeat ($urandom_range(0, 3)) feed(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic drain_input();
    while (tx_bytes.size() != 0 || in_held) @(posedge clk);
  endtask

  // watchdog
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_frame();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // idle noise, end before length, empty frame
    feed(8'h00); feed(8'hFF); feed(8'h7F); feed(8'hA5);
    feed(BYTE_ESC); feed(BYTE_END);
    feed(BYTE_ESC); feed(8'h00); feed(BYTE_END);
    // repeated escape before length lands on the first body byte
    feed(BYTE_ESC); feed(BYTE_ESC); feed(BYTE_ESC); feed(8'h09);
    feed(8'h01); feed(8'h02); feed(8'h03); feed(8'h04);
    feed(8'h80); feed(BYTE_ESC); feed(8'hFD); feed(8'h12);
    feed(8'h00); feed(BYTE_ESC); feed(8'h55); feed(BYTE_END);
    drain_input();

    // saturating body count, then random traffic
    push_frame(260, 253, 10, 1);
    random_traffic(400);
    drain_input();
    gap_pct = 0;
    random_traffic(400);
    drain_input();
    gap_pct = 29;
    random_traffic(400);
    drain_input();

    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== escaped_frame_deframer.f =====
src/efd_pkg.sv
src/efd_decode.sv
src/escaped_frame_deframer.sv
verif/escaped_frame_deframer_tb.sv
